[rtl/btbf_pkg.sv]
// package for the bit to byte framer: framing constants, state and burst types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package btbf_pkg;

	localparam int unsigned BYTE_BITS  = 8;
	localparam int unsigned COUNT_BITS = 3;
	localparam int unsigned PAD_BASE   = 5;
	localparam int unsigned WORD_BITS  = 2 * BYTE_BITS;
	localparam int unsigned CNT_W      = 4;   // holds up to 13 results per item
	localparam int unsigned ADDR_W     = 3;
	localparam logic [BYTE_BITS-1:0] TOP_FLIP = 8'h80;

	// register index, taken from the word address bit
	localparam logic REG_MODE = 1'b0;

	localparam logic MODE_PACK   = 1'b0;
	localparam logic MODE_UNPACK = 1'b1;

	typedef struct packed {
		logic [BYTE_BITS-1:0] acc;     // partial byte, right aligned
		logic [2:0]           held;    // bits in partial byte
		logic [BYTE_BITS-1:0] hbyte;   // byte held back in unpack mode
		logic                 hvalid;
	} state_t;

	// all results caused by one item, left aligned in word
	typedef struct packed {
		logic                 pack;
		logic [WORD_BITS-1:0] word;
		logic [CNT_W-1:0]     cnt;
		logic                 last;
	} burst_t;

endpackage
`default_nettype wire

[rtl/btbf_burst_gen.sv]
// per-item logic: next framer state and the burst of results for one beat
// depends on btbf_pkg
`timescale 1ns / 1ps
`default_nettype none
module btbf_burst_gen (
	input  wire                                 mode,
	input  wire                                 in_bit,
	input  wire [btbf_pkg::BYTE_BITS-1:0]       in_byte,
	input  wire                                 in_last,
	input  wire btbf_pkg::state_t               st,
	output btbf_pkg::state_t                    st_next,
	output btbf_pkg::burst_t                    burst
);
	import btbf_pkg::*;

	logic [BYTE_BITS-1:0] acc;
	logic [CNT_W-1:0]     c;
	logic [BYTE_BITS-1:0] shifted;
	logic [2:0]           pad;
	logic [BYTE_BITS-1:0] b;
	logic [4:0]           total;
	logic [4:0]           drop;

	always_comb begin
		acc     = {st.acc[BYTE_BITS-2:0], in_bit};
		c       = CNT_W'(st.held) + 1'b1;
		shifted = BYTE_BITS'(acc << (CNT_W'(BYTE_BITS) - c));
		pad     = 3'(CNT_W'(PAD_BASE) - c);
		b       = in_byte ^ TOP_FLIP;
		total   = st.hvalid ? 5'(WORD_BITS) : 5'(BYTE_BITS);
		drop    = 5'(b[2:0]) + 5'(COUNT_BITS);

		st_next    = st;
		burst.pack = (mode == MODE_PACK);
		burst.word = '0;
		burst.cnt  = '0;
		burst.last = in_last;

		if (mode == MODE_PACK) begin
			if (!in_last) begin
				if (st.held == 3'd7) begin
					burst.word = {acc ^ TOP_FLIP, 8'h00};
					burst.cnt  = CNT_W'(1);
					st_next    = '0;
				end else begin
					st_next.acc  = acc;
					st_next.held = c[2:0];
				end
			end else begin
				st_next = '0;
				if (c <= CNT_W'(PAD_BASE)) begin
					burst.word = {(shifted | BYTE_BITS'(pad)) ^ TOP_FLIP, 8'h00};
					burst.cnt  = CNT_W'(1);
				end else begin
					// partial byte of six to eight bits needs a trailer byte
					burst.word = {shifted ^ TOP_FLIP,
						BYTE_BITS'(CNT_W'(PAD_BASE + BYTE_BITS) - c) ^ TOP_FLIP};
					burst.cnt  = CNT_W'(2);
				end
			end
		end else begin
			if (!in_last) begin
				if (st.hvalid) begin
					burst.word = {st.hbyte, 8'h00};
					burst.cnt  = CNT_W'(BYTE_BITS);
				end
				st_next.hbyte  = b;
				st_next.hvalid = 1'b1;
			end else begin
				st_next    = '0;
				burst.word = st.hvalid ? {st.hbyte, b} : {b, 8'h00};
				// oversized count drops everything
				burst.cnt  = (total > drop) ? CNT_W'(total - drop) : '0;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/btbf_emitter.sv]
// output stage: shifts one burst out a result beat at a time
// depends on btbf_pkg
`timescale 1ns / 1ps
`default_nettype none
module btbf_emitter (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire btbf_pkg::burst_t          burst_s1,
	input  wire                            valid_s1,
	output logic                           load_s1,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [btbf_pkg::BYTE_BITS-1:0] out_byte,
	output logic                           out_bit,
	output logic                           out_last
);
	import btbf_pkg::*;

	logic                 pack_s2;
	logic [WORD_BITS-1:0] word_s2;
	logic [CNT_W-1:0]     cnt_s2;
	logic                 last_s2;
	logic                 take;
	logic                 final_beat;

	assign out_valid  = (cnt_s2 != '0);
	assign take       = out_valid && !out_stall;
	assign final_beat = (cnt_s2 == CNT_W'(1));
	assign load_s1    = valid_s1 && (!out_valid || (take && final_beat));

	assign out_byte = pack_s2 ? word_s2[WORD_BITS-1 -: BYTE_BITS] : '0;
	assign out_bit  = pack_s2 ? 1'b0 : word_s2[WORD_BITS-1];
	assign out_last = last_s2 && final_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= '0;
		end else if (load_s1) begin
			cnt_s2 <= burst_s1.cnt;
		end else if (take) begin
			cnt_s2 <= cnt_s2 - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			pack_s2 <= burst_s1.pack;
			word_s2 <= burst_s1.word;
			last_s2 <= burst_s1.last;
		end else if (take) begin
			// bytes move by eight, bits by one
			word_s2 <= pack_s2 ? (word_s2 << BYTE_BITS) : (word_s2 << 1);
		end
	end

endmodule
`default_nettype wire

[rtl/bit_to_byte_framer_with_pad_count.sv]
// top level of the bit to byte framer with pad count
// depends on btbf_pkg, btbf_burst_gen, btbf_emitter
`timescale 1ns / 1ps
`default_nettype none
// usage
//   register mode (apb, byte address 0): 0 packs bits into bytes, 1 unpacks
//   bytes into bits; writing it starts a new stream. write only when idle.
//   input channel in_valid / in_stall carries in_bit, in_byte and in_last;
//   output channel out_valid / out_stall carries out_byte, out_bit, out_last.
//   a beat moves on a rising edge with valid high and stall low.
// pipeline and throughput
//   each input beat is worked out in the cycle it is accepted and lands in a
//   one-burst holding register, then in the emitter, which sends one result
//   per cycle while out_stall is low and takes the next burst as the last
//   result of the one before moves. the emitter sets the rate: one byte per
//   eight bits in pack mode (two at a padded end), eight per byte in unpack
//   mode, up to thirteen at the end of an unpack stream. items with no result
//   (most pack bits) go at one per cycle while in_stall is low.
// reset and stall
//   arst_n clears the mode to pack, the framer state and both stages.
//   a stalled receiver freezes the emitter; an empty holding register still
//   takes one beat that has results, then in_stall rises until the emitter frees it.
module bit_to_byte_framer_with_pad_count (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire [btbf_pkg::ADDR_W-1:0]     paddr,
	input  wire [31:0]                     pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire                            in_bit,
	input  wire [btbf_pkg::BYTE_BITS-1:0]  in_byte,
	input  wire                            in_last,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [btbf_pkg::BYTE_BITS-1:0] out_byte,
	output logic                           out_bit,
	output logic                           out_last
);
	import btbf_pkg::*;

	logic   mode_q;
	state_t st_q;
	state_t st_next;
	burst_t burst;
	burst_t burst_s1;
	logic   valid_s1;
	logic   load_s1;
	logic   in_take;
	logic   cfg_wr;

	// apb: always ready, word index from address bit two
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MODE);
	assign prdata = (paddr[2] == REG_MODE) ? {31'd0, mode_q} : 32'd0;

	// holding register takes a beat when empty or when it hands over now
	assign in_stall = valid_s1 && !load_s1;
	assign in_take  = in_valid && !in_stall;

	btbf_burst_gen u_gen (
		.mode    (mode_q),
		.in_bit  (in_bit),
		.in_byte (in_byte),
		.in_last (in_last),
		.st      (st_q),
		.st_next (st_next),
		.burst   (burst)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_PACK;
			st_q     <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_wr) begin
				mode_q <= pwdata[0];
				st_q   <= '0;  // new stream
			end else if (in_take) begin
				st_q <= st_next;
			end
			// items that cause no result never occupy the holding register
			if (in_take) begin
				valid_s1 <= (burst.cnt != '0);
			end else if (load_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			burst_s1 <= burst;
		end
	end

	btbf_emitter u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.burst_s1  (burst_s1),
		.valid_s1  (valid_s1),
		.load_s1   (load_s1),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.out_bit   (out_bit),
		.out_last  (out_last)
	);

endmodule
`default_nettype wire

[dv/testbench.sv]
// testbench for bit_to_byte_framer_with_pad_count: directed and random bit and byte
// streams in both modes, each output beat checked against an in-bench framer model
// depends on btbf_pkg and the framer rtl
`timescale 1ns / 1ps
module testbench;
	import btbf_pkg::*;

	localparam logic [ADDR_W-1:0] MODE_ADDR = {REG_MODE, 2'b00};
	localparam int unsigned SETTLE_CYCLES = 8;   // pipeline depth plus margin

	typedef struct {
		logic [BYTE_BITS-1:0] obyte;
		logic                 obit;
		logic                 olast;
	} framer_beat_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 psel, penable, pwrite;
	logic [ADDR_W-1:0]    paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;
	logic                 in_valid, in_stall, in_bit, in_last;
	logic [BYTE_BITS-1:0] in_byte;
	logic                 out_valid, out_stall, out_bit, out_last;
	logic [BYTE_BITS-1:0] out_byte;

	// expected output beats, oldest first
	framer_beat_t pending_beats[$];

	// framer model state
	logic                 cur_mode;
	logic [BYTE_BITS-1:0] pk_acc;
	logic [2:0]           pk_count;
	logic [BYTE_BITS-1:0] up_byte;
	logic                 up_held;

	int unsigned items_sent = 0;
	int unsigned errors = 0;
	bit          idle_on = 1'b1;
	int unsigned stall_run = 0;

	bit_to_byte_framer_with_pad_count dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .in_bit(in_bit),
		.in_byte(in_byte), .in_last(in_last),
		.out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
		.out_bit(out_bit), .out_last(out_last)
	);

	always #5 clk = ~clk;

	// ---------------- framer model ----------------

	function automatic void clear_framer_model();
		pk_acc   = '0;
		pk_count = '0;
		up_byte  = '0;
		up_held  = 1'b0;
	endfunction

	function automatic void push_beat(logic [BYTE_BITS-1:0] by, logic bi, logic la);
		framer_beat_t t;
		t.obyte = by;
		t.obit  = bi;
		t.olast = la;
		pending_beats.insert(pending_beats.size(), t);
	endfunction

	// pack: msb first into bytes, trailer of zeros plus 3-bit pad count
	function automatic void predict_pack_bit(logic b, logic lst);
		logic [BYTE_BITS:0]   acc;
		logic [BYTE_BITS-1:0] w;
		int unsigned          c;
		acc = {pk_acc, b};
		c = pk_count + 1;
		if (!lst) begin
			if (c == BYTE_BITS) begin
				push_beat(acc[BYTE_BITS-1:0] ^ TOP_FLIP, 1'b0, 1'b0);
				pk_acc   = '0;
				pk_count = '0;
			end else begin
				pk_acc   = acc[BYTE_BITS-1:0];
				pk_count = 3'(c);
			end
		end else begin
			clear_framer_model();
			w = BYTE_BITS'(acc << (BYTE_BITS - c));
			if (c <= PAD_BASE) begin
				// count fits in the same byte
				push_beat((w | BYTE_BITS'(PAD_BASE - c)) ^ TOP_FLIP, 1'b0, 1'b1);
			end else begin
				// six to eight bits: count spills into an extra trailer byte
				push_beat(w ^ TOP_FLIP, 1'b0, 1'b0);
				push_beat(BYTE_BITS'(PAD_BASE + BYTE_BITS - c) ^ TOP_FLIP, 1'b0, 1'b1);
			end
		end
	endfunction

	// unpack: one byte held back, trailer drops count plus 3 bits
	function automatic void predict_unpack_byte(logic [BYTE_BITS-1:0] raw, logic lst);
		logic [BYTE_BITS-1:0] b;
		logic [WORD_BITS-1:0] word;
		int unsigned          total, drop, keep, i;
		b = raw ^ TOP_FLIP;
		if (!lst) begin
			if (up_held) begin
				for (i = 0; i < BYTE_BITS; i++)
					push_beat('0, up_byte[BYTE_BITS-1-i], 1'b0);
			end
			up_byte = b;
			up_held = 1'b1;
		end else begin
			word  = {8'h00, b};
			total = BYTE_BITS;
			if (up_held) begin
				word  = {up_byte, b};
				total = WORD_BITS;
			end
			drop = b[2:0] + COUNT_BITS;
			// oversized count on a lone byte drops everything
			keep = (total > drop) ? total - drop : 0;
			for (i = 0; i < keep; i++)
				push_beat('0, word[total-1-i], (i + 1 == keep));
			clear_framer_model();
		end
	endfunction

	// ---------------- drivers ----------------

	// one beat on the input channel; valid stays high for the next beat unless a gap follows
	task automatic send_item(logic b, logic [BYTE_BITS-1:0] by, logic lst);
		int unsigned gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_bit   <= b;
		in_byte  <= by;
		in_last  <= lst;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		if (cur_mode == MODE_PACK)
			predict_pack_bit(b, lst);
		else
			predict_unpack_byte(by, lst);
	endtask

	// hold off the sender until every expected beat is out and the pipeline is empty
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// apb write of mode then readback; caller makes sure the block is idle
	task automatic write_mode(logic m);
		logic [31:0] w;
		w = $urandom;
		w[0] = m;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= MODE_ADDR;
		pwdata  <= w;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		cur_mode = m;
		clear_framer_model();
		// read setup in the same step as the write completes
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[0] !== m) begin
			$error("mode readback expected %0h got %0h", m, prdata[0]);
			errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_pack_stream(int unsigned len, bit finish);
		int unsigned i;
		for (i = 0; i < len; i++)
			send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
				finish && (i + 1 == len));
	endtask

	task automatic send_unpack_stream(int unsigned len, bit finish);
		int unsigned i;
		for (i = 0; i < len; i++)
			send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
				finish && (i + 1 == len));
	endtask

	// ---------------- output side: stall bursts and beat check ----------------

	always @(posedge clk) begin
		framer_beat_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_beats.size() == 0) begin
				$error("output beat with nothing expected: byte %0h bit %0h last %0h",
					out_byte, out_bit, out_last);
				errors++;
			end else begin
				e = pending_beats.pop_front();
				if (out_byte !== e.obyte) begin
					$error("out_byte expected %0h got %0h", e.obyte, out_byte);
					errors++;
				end
				if (out_bit !== e.obit) begin
					$error("out_bit expected %0h got %0h", e.obit, out_bit);
					errors++;
				end
				if (out_last !== e.olast) begin
					$error("out_last expected %0h got %0h", e.olast, out_last);
					errors++;
				end
			end
		end
		// receiver stall bursts start at random while idle_on is set
		if (stall_run != 0) begin
			stall_run--;
			out_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_run = $urandom_range(1, 6) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ---------------- tests ----------------

	// every final partial length class: short pad, pad to five, spill to trailer byte
	task automatic test_pack_padding();
		int unsigned i;
		write_mode(MODE_PACK);
		send_item(1'b1, 8'h00, 1'b1);                        // one bit, pad count 4
		for (i = 0; i < 5; i++) send_item(1'b1, 8'hff, i == 4);  // five bits, count 0
		for (i = 0; i < 6; i++) send_item(1'b0, 8'h00, i == 5);  // six bits, extra byte
		for (i = 0; i < 8; i++) send_item(i[0], 8'hff, i == 7);  // full byte at the end
	endtask

	task automatic test_unpack_trailer();
		wait_drained();
		write_mode(MODE_UNPACK);
		send_item(1'b0, 8'h00, 1'b1);   // lone byte, count 0: five bits
		send_item(1'b1, 8'hff, 1'b1);   // lone byte, oversized count: nothing
		send_item(1'b0, 8'hff, 1'b0);   // held byte then count 7
		send_item(1'b1, 8'h7f, 1'b1);
		send_item(1'b0, 8'h00, 1'b0);   // longest burst at the end: thirteen bits
		send_item(1'b1, 8'hff, 1'b0);
		send_item(1'b0, 8'h80, 1'b1);
	endtask

	// a mode write drops a partial stream in either mode
	task automatic test_mode_clears_stream();
		wait_drained();
		write_mode(MODE_PACK);
		send_item(1'b1, 8'h55, 1'b0);
		send_item(1'b1, 8'haa, 1'b0);
		send_item(1'b0, 8'h55, 1'b0);
		wait_drained();
		write_mode(MODE_PACK);
		send_item(1'b1, 8'h00, 1'b0);
		send_item(1'b0, 8'h00, 1'b1);
		wait_drained();
		write_mode(MODE_UNPACK);
		send_item(1'b0, 8'h3c, 1'b0);
		wait_drained();
		write_mode(MODE_UNPACK);
		send_item(1'b0, 8'hc3, 1'b1);
	endtask

	// phases of random streams in a random mode; the last stream may be cut off
	task automatic test_random_streams(int unsigned upto);
		logic        m;
		int unsigned n, k, len;
		bit          finish;
		while (items_sent < upto) begin
			wait_drained();
			m = 1'($urandom_range(0, 1));
			write_mode(m);
			n = $urandom_range(1, 5);
			for (k = 0; k < n; k++) begin
				finish = (k + 1 < n) || ($urandom_range(0, 4) != 0);
				if (m == MODE_PACK) begin
					len = $urandom_range(1, 20);
					send_pack_stream(len, finish);
				end else begin
					len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 5);
					send_unpack_stream(len, finish);
				end
			end
		end
	endtask

	// back to back beats with no input gaps and no receiver stalls
	task automatic test_back_to_back(int unsigned upto);
		wait_drained();
		idle_on = 1'b0;
		test_random_streams(upto);
	endtask

	// ---------------- main sequence ----------------

	initial begin
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		in_valid  = 1'b0;
		in_bit    = 1'b0;
		in_byte   = '0;
		in_last   = 1'b0;
		out_stall = 1'b0;
		cur_mode  = MODE_PACK;
		clear_framer_model();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_pack_padding();
		test_unpack_trailer();
		test_mode_clears_stream();
		test_random_streams(400);
		test_back_to_back(460);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// watchdog, far above the slowest correct run
	initial begin
		#5ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
